// ----- hw/rtl/uphps_pkg.sv -----
// ----------------------------------------------------------------------------
// Unpremultiply half pixel scale package
// Shared types, constants and arithmetic helpers for the pixel pipeline.
// ----------------------------------------------------------------------------
package uphps_pkg;

  localparam int unsigned HalfW   = 16;
  localparam int unsigned SingleW = 32;
  localparam int unsigned Lanes   = 3;

  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
  localparam logic [15:0] HALF_ONE   = 16'h3C00;
  localparam logic [10:0] SIG_ONE    = 11'h400;

  localparam logic [0:0] REG_COLOUR_SCALE = 1'b0;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_NORM = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } fclass_e;

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic [10:0]        sig;
    logic signed [6:0]  expo;
  } half_num_t;

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic [23:0]        sig;
    logic signed [9:0]  expo;
  } scale_t;

  localparam scale_t SCALE_ONE = '{cls: CLS_NORM, sign: 1'b0, sig: 24'h80_0000, expo: 10'sd0};

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic signed [7:0]  expo;
    logic [11:0]        rem;
    logic [26:0]        quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]    lane;
    logic [10:0]        dvs;
    logic [31:0]        alpha;
  } div_stage_t;

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic signed [7:0]  expo;
    logic [23:0]        sig;
  } quo_lane_t;

  typedef struct packed {
    quo_lane_t [2:0]    lane;
    logic [31:0]        alpha;
  } quo_stage_t;

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic signed [10:0] esum;
    logic [47:0]        prod;
  } mul_lane_t;

  typedef struct packed {
    mul_lane_t [2:0]    lane;
    logic [31:0]        alpha;
  } mul_stage_t;

  typedef struct packed {
    fclass_e            cls;
    logic               sign;
    logic               ovf;
    logic [30:0]        mag;
    logic               grd;
    logic               stk;
  } nrm_lane_t;

  typedef struct packed {
    nrm_lane_t [2:0]    lane;
    logic [31:0]        alpha;
  } nrm_stage_t;

  // Splits a binary16 word into class, sign and a normalized significand.
  function automatic half_num_t unpack_half(input logic [15:0] h);
    half_num_t   res;
    logic [4:0]  he;
    logic [9:0]  m;
    logic [3:0]  p;
    he = h[14:10];
    m  = h[9:0];
    p  = 4'd0;
    res.sign = h[15];
    res.sig  = {1'b1, m};
    res.expo = 7'sd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        p = 4'(i);
      end
    end
    if (he == 5'h1F) begin
      res.cls = (m != 10'd0) ? CLS_NAN : CLS_INF;
    end else if (he == 5'd0) begin
      res.cls  = (m == 10'd0) ? CLS_ZERO : CLS_NORM;
      res.sig  = 11'({1'b0, m} << (4'd10 - p));
      res.expo = signed'({3'b000, p} - 7'd24);
    end else begin
      res.cls  = CLS_NORM;
      res.expo = signed'({2'b00, he} - 7'd15);
    end
    return res;
  endfunction

  // Exact widening of a binary16 word to binary32.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    half_num_t   u;
    logic [7:0]  ef;
    u  = unpack_half(h);
    ef = {u.expo[6], u.expo} + 8'd127;
    if (h[14:10] == 5'h1F) begin
      return {h[15], 8'hFF, h[9:0], 13'd0};
    end else if (u.cls == CLS_ZERO) begin
      return {h[15], 31'd0};
    end
    return {h[15], ef, u.sig[9:0], 13'd0};
  endfunction

  // Splits a binary32 word into class, sign and a normalized significand.
  function automatic scale_t unpack_single(input logic [31:0] w);
    scale_t      res;
    logic [7:0]  e8;
    logic [22:0] m;
    logic [4:0]  p;
    e8 = w[30:23];
    m  = w[22:0];
    p  = 5'd0;
    res.sign = w[31];
    res.sig  = {1'b1, m};
    res.expo = 10'sd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    if (e8 == 8'hFF) begin
      res.cls = (m != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (e8 == 8'd0) begin
      res.cls  = (m == 23'd0) ? CLS_ZERO : CLS_NORM;
      res.sig  = 24'({1'b0, m} << (5'd23 - p));
      res.expo = signed'({5'd0, p} - 10'd149);
    end else begin
      res.cls  = CLS_NORM;
      res.expo = signed'({2'b00, e8} - 10'd127);
    end
    return res;
  endfunction

  // Runs up to seven restoring division steps on one lane.
  function automatic div_lane_t div_iter(input div_lane_t li, input logic [10:0] d,
                                         input logic first, input int n);
    div_lane_t   lo;
    logic [11:0] r;
    logic [26:0] q;
    lo = li;
    r  = li.rem;
    q  = li.quo;
    for (int j = 0; j < 7; j++) begin
      if (j < n) begin
        if (!(first && (j == 0))) begin
          r = {r[10:0], 1'b0};
        end
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q = {q[25:0], 1'b1};
        end else begin
          q = {q[25:0], 1'b0};
        end
      end
    end
    lo.rem = r;
    lo.quo = q;
    return lo;
  endfunction

endpackage

// ----- hw/rtl/unpremultiply_half_pixel_scale.sv -----
// ----------------------------------------------------------------------------
// Unpremultiply half pixel scale
// Widens a binary16 RGBA pixel to binary32, divides the colours by alpha and
// scales them by a configured binary32 factor, with round to nearest even.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: red, green, blue, alpha (binary16 each)
//  m_axis    out        tdata: red, green, blue, alpha (binary32), tuser: not_finite
//  apb       in/out     colour_scale register at byte address 0
//
// One pixel is taken in every cycle while the output is not stalled; each
// result passes through the 27-step restoring divider, spread over four
// stages, and the 24 by 24 bit multiplier with its normalizer.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and no pixel is lost or repeated. Reset empties the pipeline and loads
// a scale of 1.0.
module unpremultiply_half_pixel_scale (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // red_half, green_half, blue_half, alpha_half
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // red_single, green_single, blue_single, alpha_single
  output logic         m_axis_tuser,   // not_finite
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned Stages = 9;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;

  logic [31:0]       scale_raw_q;
  uphps_pkg::scale_t scale_q;

  uphps_pkg::div_stage_t div0_d;
  uphps_pkg::div_stage_t div_d [1:4];
  uphps_pkg::div_stage_t div_q [0:4];
  uphps_pkg::quo_stage_t quo_d, quo_q;
  uphps_pkg::mul_stage_t mul_d, mul_q;
  uphps_pkg::nrm_stage_t nrm_d, nrm_q;
  logic [127:0]          out_data_d, out_data_q;
  logic                  out_nf_d, out_nf_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == uphps_pkg::REG_COLOUR_SCALE) ? scale_raw_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_raw_q <= uphps_pkg::ONE_BITS;
      scale_q     <= uphps_pkg::SCALE_ONE;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == uphps_pkg::REG_COLOUR_SCALE)) begin
      scale_raw_q <= pwdata;
      scale_q     <= uphps_pkg::unpack_single(pwdata);
    end
  end

  // Pipeline flow control.
  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || m_axis_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: unpack the halves and choose the divisor.
  always_comb begin
    uphps_pkg::half_num_t ha;
    uphps_pkg::half_num_t hv;
    logic                 divide;
    logic                 ainf;
    logic                 use_sig;
    logic signed [6:0]    dexp;
    ha      = uphps_pkg::unpack_half(s_axis_tdata[63:48]);
    divide  = !ha.sign && (ha.cls != uphps_pkg::CLS_ZERO) && (ha.cls != uphps_pkg::CLS_NAN) &&
              (s_axis_tdata[63:48] != uphps_pkg::HALF_ONE);
    ainf    = divide && (ha.cls == uphps_pkg::CLS_INF);
    use_sig = divide && (ha.cls == uphps_pkg::CLS_NORM);
    dexp    = use_sig ? ha.expo : 7'sd0;
    div0_d.dvs   = use_sig ? ha.sig : uphps_pkg::SIG_ONE;
    div0_d.alpha = uphps_pkg::widen_half(s_axis_tdata[63:48]);
    for (int l = 0; l < 3; l++) begin
      hv = uphps_pkg::unpack_half(s_axis_tdata[16*l +: 16]);
      unique case (hv.cls)
        uphps_pkg::CLS_NAN:  div0_d.lane[l].cls = uphps_pkg::CLS_NAN;
        uphps_pkg::CLS_INF:  div0_d.lane[l].cls = ainf ? uphps_pkg::CLS_NAN
                                                       : uphps_pkg::CLS_INF;
        uphps_pkg::CLS_ZERO: div0_d.lane[l].cls = uphps_pkg::CLS_ZERO;
        default:             div0_d.lane[l].cls = ainf ? uphps_pkg::CLS_ZERO
                                                       : uphps_pkg::CLS_NORM;
      endcase
      div0_d.lane[l].sign = hv.sign;
      div0_d.lane[l].expo = signed'({hv.expo[6], hv.expo} - {dexp[6], dexp});
      div0_d.lane[l].rem  = {1'b0, hv.sig};
      div0_d.lane[l].quo  = 27'd0;
    end
  end

  // Stages 1 to 4: restoring division, seven quotient bits per stage, six in stage 4.
  always_comb begin
    for (int k = 1; k < 5; k++) begin
      div_d[k] = div_q[k-1];
      for (int l = 0; l < 3; l++) begin
        div_d[k].lane[l] = uphps_pkg::div_iter(div_q[k-1].lane[l], div_q[k-1].dvs,
                                               (k == 1), (k == 4) ? 6 : 7);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      div_q[0] <= div0_d;
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // Stage 5: round the quotient to a binary32 significand.
  always_comb begin
    uphps_pkg::div_lane_t dl;
    logic [23:0]          sig;
    logic                 grd;
    logic                 stk;
    logic [24:0]          sum;
    logic signed [7:0]    e;
    quo_d.alpha = div_q[4].alpha;
    for (int l = 0; l < 3; l++) begin
      dl = div_q[4].lane[l];
      if (dl.quo[26]) begin
        sig = dl.quo[26:3];
        grd = dl.quo[2];
        stk = (dl.quo[1:0] != 2'd0) || (dl.rem != 12'd0);
        e   = dl.expo;
      end else begin
        sig = dl.quo[25:2];
        grd = dl.quo[1];
        stk = dl.quo[0] || (dl.rem != 12'd0);
        e   = dl.expo - 8'sd1;
      end
      sum = {1'b0, sig} + {24'd0, grd && (stk || sig[0])};
      if (sum[24]) begin
        sig = sum[24:1];
        e   = e + 8'sd1;
      end else begin
        sig = sum[23:0];
      end
      quo_d.lane[l].cls  = dl.cls;
      quo_d.lane[l].sign = dl.sign;
      quo_d.lane[l].expo = e;
      quo_d.lane[l].sig  = sig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      quo_q <= quo_d;
    end
  end

  // Stage 6: multiply by the scale and resolve special operands.
  always_comb begin
    uphps_pkg::quo_lane_t ql;
    mul_d.alpha = quo_q.alpha;
    for (int l = 0; l < 3; l++) begin
      ql = quo_q.lane[l];
      if ((ql.cls == uphps_pkg::CLS_NAN) || (scale_q.cls == uphps_pkg::CLS_NAN) ||
          ((ql.cls == uphps_pkg::CLS_INF) && (scale_q.cls == uphps_pkg::CLS_ZERO)) ||
          ((ql.cls == uphps_pkg::CLS_ZERO) && (scale_q.cls == uphps_pkg::CLS_INF))) begin
        mul_d.lane[l].cls = uphps_pkg::CLS_NAN;
      end else if ((ql.cls == uphps_pkg::CLS_INF) || (scale_q.cls == uphps_pkg::CLS_INF)) begin
        mul_d.lane[l].cls = uphps_pkg::CLS_INF;
      end else if ((ql.cls == uphps_pkg::CLS_ZERO) ||
                   (scale_q.cls == uphps_pkg::CLS_ZERO)) begin
        mul_d.lane[l].cls = uphps_pkg::CLS_ZERO;
      end else begin
        mul_d.lane[l].cls = uphps_pkg::CLS_NORM;
      end
      mul_d.lane[l].sign = ql.sign ^ scale_q.sign;
      mul_d.lane[l].esum = signed'({{3{ql.expo[7]}}, ql.expo} +
                                   {scale_q.expo[9], scale_q.expo});
      mul_d.lane[l].prod = {24'd0, ql.sig} * {24'd0, scale_q.sig};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      mul_q <= mul_d;
    end
  end

  // Stage 7: normalize, with gradual underflow below the normal range.
  always_comb begin
    uphps_pkg::mul_lane_t ml;
    logic [47:0]          pn;
    logic [47:0]          shifted;
    logic signed [10:0]   eb;
    logic signed [10:0]   sh;
    logic [5:0]           shc;
    logic                 lost;
    nrm_d.alpha = mul_q.alpha;
    for (int l = 0; l < 3; l++) begin
      ml      = mul_q.lane[l];
      pn      = ml.prod[47] ? ml.prod : {ml.prod[46:0], 1'b0};
      eb      = ml.esum + 11'sd127 + (ml.prod[47] ? 11'sd1 : 11'sd0);
      sh      = 11'sd1 - eb;
      shc     = (sh > 11'sd49) ? 6'd49 : sh[5:0];
      shifted = pn >> shc;
      lost    = |(pn & ~({48{1'b1}} << shc));
      nrm_d.lane[l].cls  = ml.cls;
      nrm_d.lane[l].sign = ml.sign;
      nrm_d.lane[l].ovf  = (eb >= 11'sd255);
      if (eb >= 11'sd1) begin
        nrm_d.lane[l].mag = {eb[7:0], pn[46:24]};
        nrm_d.lane[l].grd = pn[23];
        nrm_d.lane[l].stk = |pn[22:0];
      end else begin
        nrm_d.lane[l].mag = {8'd0, shifted[46:24]};
        nrm_d.lane[l].grd = shifted[23];
        nrm_d.lane[l].stk = (|shifted[22:0]) || lost;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      nrm_q <= nrm_d;
    end
  end

  // Stage 8: round, pack and flag non-finite results.
  always_comb begin
    uphps_pkg::nrm_lane_t nl;
    logic [31:0]          w;
    logic                 nf;
    nf = (nrm_q.alpha[30:23] == 8'hFF);
    for (int l = 0; l < 3; l++) begin
      nl = nrm_q.lane[l];
      unique case (nl.cls)
        uphps_pkg::CLS_NAN:  w = uphps_pkg::CANON_NAN;
        uphps_pkg::CLS_INF:  w = {nl.sign, 8'hFF, 23'd0};
        uphps_pkg::CLS_ZERO: w = {nl.sign, 31'd0};
        default: begin
          if (nl.ovf) begin
            w = {nl.sign, 8'hFF, 23'd0};
          end else begin
            w = {nl.sign, nl.mag + {30'd0, nl.grd && (nl.stk || nl.mag[0])}};
          end
        end
      endcase
      out_data_d[32*l +: 32] = w;
      nf = nf || (w[30:23] == 8'hFF);
    end
    out_data_d[127:96] = nrm_q.alpha;
    out_nf_d           = nf;
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      out_data_q <= out_data_d;
      out_nf_q   <= out_nf_d;
    end
  end

  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_nf_q;

endmodule

// ----- hw/rtl/uphps_checker.sv -----
// ----------------------------------------------------------------------------
// Unpremultiply half pixel scale checker
// Port-level assertions on results and the configuration port.
// ----------------------------------------------------------------------------
module uphps_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         pready
);

  a_pready_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready == 1'b1) else $error("pready dropped");

  a_alpha_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[126:119] == 8'hFF)) |-> m_axis_tuser)
    else $error("non-finite alpha without flag");

  a_red_canon_nan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0))
    |-> (m_axis_tdata[31:0] == 32'h7FC0_0000))
    else $error("red NaN not canonical");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind unpremultiply_half_pixel_scale uphps_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Pixel unpremultiply and scale testbench
// Sends half-precision RGBA pixels over the input stream and checks every
// output transfer against a bit-exact single-precision predictor, across
// several colour scale settings, random idling on both sides and a long
// output stall.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
    logic        not_finite;
  } pixel_out_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  pixel_out_t  expected_pixels[$];
  logic [31:0] scale_bits;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_requests;
  int unsigned stall_seen;
  int unsigned stall_left;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  unpremultiply_half_pixel_scale i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [9:0] m;
    int         e;
    m = h[9:0];
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, m, 13'd0};
    if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10] + 112), m, 13'd0};
    if (m == 10'd0) return {h[15], 31'd0};
    e = 113;
    while (!m[9]) begin
      m = m << 1;
      e--;
    end
    return {h[15], 8'(e - 1), m[8:0], 14'd0};
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] w);
    logic [23:0] m;
    int          e;
    m = {1'b0, w[22:0]};
    if (w[30:23] == 8'hFF) return {w[31], 11'h7FF, w[22:0], 29'd0};
    if (w[30:23] != 8'd0) return {w[31], 11'(w[30:23] - 127 + 1023), w[22:0], 29'd0};
    if (m == 24'd0) return {w[31], 63'd0};
    e = -126;
    while (!m[23]) begin
      m = m << 1;
      e--;
    end
    return {w[31], 11'(e + 1023), m[22:0], 29'd0};
  endfunction

  // Round a double to binary32, nearest even, with gradual underflow.
  function automatic logic [31:0] double_to_single(input logic [63:0] d);
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rest;
    logic [63:0] half;
    int          e;
    int          sh;
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? uphps_pkg::CANON_NAN : {d[63], 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e   = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    rest = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
    if (e < -126) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      e++;
    end
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    return {d[63], 8'(e + 127), kept[22:0]};
  endfunction

  function automatic logic [31:0] single_div(input logic [31:0] x, input logic [31:0] y);
    real q;
    q = $bitstoreal(single_to_double(x)) / $bitstoreal(single_to_double(y));
    return double_to_single($realtobits(q));
  endfunction

  function automatic logic [31:0] single_mul(input logic [31:0] x, input logic [31:0] y);
    real p;
    p = $bitstoreal(single_to_double(x)) * $bitstoreal(single_to_double(y));
    return double_to_single($realtobits(p));
  endfunction

  function automatic logic all_ones_exp(input logic [31:0] w);
    return w[30:23] == 8'hFF;
  endfunction

  function automatic pixel_out_t unpremultiply_pixel(input logic [63:0] px);
    pixel_out_t  o;
    logic [31:0] a;
    logic [31:0] c[3];
    logic        divide;
    a = half_to_single(px[63:48]);
    divide = !a[31] && (a[30:0] != 31'd0) && !(all_ones_exp(a) && a[22:0] != 0)
             && (a != uphps_pkg::ONE_BITS);
    for (int i = 0; i < 3; i++) begin
      c[i] = half_to_single(px[16*i +: 16]);
      if (divide) c[i] = single_div(c[i], a);
      c[i] = single_mul(c[i], scale_bits);
    end
    o.red   = c[0];
    o.green = c[1];
    o.blue  = c[2];
    o.alpha = a;
    o.not_finite = all_ones_exp(c[0]) || all_ones_exp(c[1]) || all_ones_exp(c[2])
                   || all_ones_exp(a);
    return o;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'(uphps_pkg::REG_COLOUR_SCALE * 4)) scale_bits = data;
  endtask

  task automatic drain_and_set_scale(input logic [31:0] s);
    wait (expected_pixels.size() == 0);
    repeat (12) @(posedge clk_i);
    apb_write(3'(uphps_pkg::REG_COLOUR_SCALE * 4), s);
  endtask

  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] a);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(3, 1);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.insert(expected_pixels.size(), unpremultiply_pixel({a, b, g, r}));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] random_half(input logic [15:0] alpha);
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(9))
      0:       h = {h[15], 5'h1F, h[9:0]};
      1:       h = {h[15], 5'd0, h[9:0]};
      2, 3, 4: h = 16'($urandom_range(alpha[14:0]));
      default: ;
    endcase
    return h;
  endfunction

  task automatic send_random_pixel();
    logic [15:0] a;
    a = 16'($urandom_range(16'h3C00, 16'h0001));
    if ($urandom_range(9) < 3) a = 16'($urandom);
    send_pixel(random_half(a), random_half(a), random_half(a), a);
  endtask

  always @(posedge clk_i) begin
    if (stall_requests != stall_seen) begin
      stall_seen    <= stall_requests;
      stall_left    <= 300;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_out_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer %h", m_axis_tdata);
      end else begin
        e = expected_pixels.pop_front();
        if (m_axis_tdata[31:0] !== e.red || m_axis_tdata[63:32] !== e.green ||
            m_axis_tdata[95:64] !== e.blue || m_axis_tdata[127:96] !== e.alpha ||
            m_axis_tuser !== e.not_finite) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r %h g %h b %h a %h nf %b, got r %h g %h b %h a %h nf %b",
                     e.red, e.green, e.blue, e.alpha, e.not_finite,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                     m_axis_tdata[127:96], m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_special_values();
    logic [15:0] colours[10];
    logic [15:0] alphas[9];
    colours = '{16'h0000, 16'h8000, 16'h7BFF, 16'hFBFF, 16'h0001, 16'h83FF,
                16'h7C00, 16'hFC00, 16'h7E01, 16'hFD55};
    alphas  = '{16'h0000, 16'h8000, 16'hBC00, 16'h7D55, 16'h3C00, 16'h3800,
                16'h0001, 16'h7C00, 16'h7BFF};
    foreach (alphas[i]) begin
      send_pixel(colours[(i * 3) % 10], colours[(i * 3 + 1) % 10],
                 colours[(i * 3 + 2) % 10], alphas[i]);
    end
    send_pixel(16'h3C00, 16'h3555, 16'h0200, 16'h3555);
    send_pixel(16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF);
    stop_sending();
  endtask

  task automatic test_scale_extremes();
    logic [31:0] scales[9];
    scales = '{32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h3A80_0801};
    foreach (scales[i]) begin
      drain_and_set_scale(scales[i]);
      repeat (8) send_random_pixel();
      stop_sending();
    end
    drain_and_set_scale(32'h1234_5678);
    apb_write(3'd4, 32'hDEAD_BEEF);
    repeat (8) send_random_pixel();
    stop_sending();
  endtask

  task automatic test_random_traffic();
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 63 : 0;
      recv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 7 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        drain_and_set_scale((blk == 0) ? uphps_pkg::ONE_BITS
                                       : $urandom_range(32'h4200_0000, 32'h3000_0000));
        repeat (130) send_random_pixel();
        stop_sending();
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_set_scale(32'h3F40_0000);
    stall_requests++;
    repeat (60) send_random_pixel();
    stop_sending();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    scale_bits     = uphps_pkg::ONE_BITS;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_requests = 0;
    stall_seen     = 0;
    stall_left     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_scale_extremes();
    test_random_traffic();
    test_output_stall();
    wait (expected_pixels.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
